/* design/dnsdec_pkg.sv */
`default_nettype none

package dnsdec_pkg;

	// parameter defaults
	localparam int PKT_DEPTH_DEF  = 8192;
	localparam int NAME_DEPTH_DEF = 256;
	localparam int MAX_STEPS_DEF  = 128;

	// fixed field widths
	localparam int POS_W  = 14;
	localparam int BYTE_W = 8;
	localparam int PLEN_W = 14;
	localparam int END_W  = 14;
	localparam int NLEN_W = 8;

	// walk position width: a 14-bit offset plus one label still fits
	localparam int AW = 15;

	// bus widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;
	localparam int S_TUSER_W = 2;

	// length byte codes
	localparam logic [7:0] PTR_MARK = 8'hc0;
	localparam logic [7:0] PTR_LOW  = 8'h3f;
	localparam logic [7:0] DOT_CHAR = 8'h2e;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_DECODE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

endpackage

`default_nettype wire

/* design/dns_name_decompressor.sv */
// Channel  Dir  Beat fields (low bit up)
// s_*      in   tuser: req_type[1:0]
//               tdata: position[13:0], write_byte[21:14], packet_length[35:22], zero[39:36]
// m_*      out  tdata: end_offset[13:0], name_length[21:14], read_byte[29:22], zero[31:30]
//
// Write, read and idle requests are taken back to back while the result buffer has room; each
// result passes through stage one and the head register. A decode keeps s_tready low while it
// walks the single read port of the packet memory one byte per cycle, and while it waits in
// ST_DONE for room in the result buffer.
// Reset clears control and the name count only; both memories hold garbage until written.
// A full two-beat result buffer stalls s_tready and holds a decode in ST_DONE.
`default_nettype none

module dns_name_decompressor #(
	parameter int PKT_DEPTH  = dnsdec_pkg::PKT_DEPTH_DEF,
	parameter int NAME_DEPTH = dnsdec_pkg::NAME_DEPTH_DEF,
	parameter int MAX_STEPS  = dnsdec_pkg::MAX_STEPS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// position, write_byte, packet_length, zero pad
	input  wire logic [dnsdec_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type
	input  wire logic [dnsdec_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// end_offset, name_length, read_byte, zero pad
	output logic [dnsdec_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int PW = $clog2(PKT_DEPTH);
	localparam int NW = $clog2(NAME_DEPTH);
	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int AW = dnsdec_pkg::AW;
	localparam int CW = (NW > 8) ? NW : 8;

	typedef struct packed {
		logic [dnsdec_pkg::BYTE_W-1:0] read_byte;
		logic [dnsdec_pkg::NLEN_W-1:0] name_length;
		logic [dnsdec_pkg::END_W-1:0]  end_offset;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEN,
		ST_PTR,
		ST_COPY,
		ST_DONE
	} state_t;

	function automatic logic [7:0] sat_count(input logic [NW-1:0] c);
		logic [CW-1:0] e;
		e = CW'(c);
		return (e > CW'(255)) ? 8'hff : e[7:0];
	endfunction

	// input fields
	dnsdec_pkg::req_t                in_req;
	logic [dnsdec_pkg::POS_W-1:0]    in_pos;
	logic [dnsdec_pkg::BYTE_W-1:0]   in_byte;
	logic [dnsdec_pkg::PLEN_W-1:0]   in_plen;
	logic                            accept;

	assign in_req  = dnsdec_pkg::req_t'(s_tuser);
	assign in_pos  = s_tdata[13:0];
	assign in_byte = s_tdata[21:14];
	assign in_plen = s_tdata[35:22];
	assign accept  = s_tvalid && s_tready;

	// walk state
	state_t          state_q;
	logic [AW-1:0]   at_q;
	logic [AW-1:0]   end_q;
	logic [AW-1:0]   bound_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [SW-1:0]   steps_q;
	logic            followed_q;
	logic [5:0]      ptr_hi_q;
	logic [7:0]      left_q;
	logic [NW-1:0]   cnt_q;

	// memories
	logic [7:0]      pkt_mem [PKT_DEPTH];
	logic [7:0]      name_mem [NAME_DEPTH-1];
	logic [7:0]      pkt_rdata_q;
	logic [7:0]      name_rdata_q;
	logic            pkt_we, pkt_re, name_we, name_re;
	logic [PW-1:0]   pkt_raddr;
	logic [NW-1:0]   name_waddr;
	logic [7:0]      name_wdata;

	// first pipeline stage for write, read and idle requests
	logic            v_s1;
	logic            hit_s1;
	result_t         res_s1;

	// result buffer: head register drives the port, skid behind it
	logic            head_v_q, skid_v_q;
	result_t         head_q, skid_q;
	logic            pop, push, room;
	result_t         push_data;
	logic [2:0]      used;

	// decode of the current length byte
	logic [7:0]      len;
	logic [AW-1:0]   at_p1, lab_end;
	logic            is_zero, is_ptr, ptr_oob, lab_oob, can_step, name_room, rd_hit;
	logic [AW-1:0]   bound_new;

	assign len       = pkt_rdata_q;
	assign at_p1     = at_q + AW'(1);
	assign lab_end   = at_q + AW'(1) + AW'(len);
	assign is_zero   = (len == 8'd0);
	assign is_ptr    = ((len & dnsdec_pkg::PTR_MARK) == dnsdec_pkg::PTR_MARK);
	assign ptr_oob   = (at_p1 >= bound_q);
	assign lab_oob   = (lab_end > bound_q);
	assign can_step  = (at_q < bound_q) && (steps_q < SW'(MAX_STEPS));
	assign name_room = (cnt_q < NW'(NAME_DEPTH - 1));
	assign rd_hit    = (in_pos < dnsdec_pkg::POS_W'(cnt_q));
	assign bound_new = (AW'(in_plen) < AW'(PKT_DEPTH)) ? AW'(in_plen) : AW'(PKT_DEPTH);

	// buffer occupancy once stage one and this cycle's pop settle
	assign pop      = head_v_q && m_tready;
	assign used     = 3'(head_v_q) + 3'(skid_v_q) + 3'(v_s1) - 3'(pop);
	assign room     = (used < 3'd2);
	assign s_tready = (state_q == ST_IDLE) && room;

	// pick the result entering the buffer
	always_comb begin
		push      = v_s1 || ((state_q == ST_DONE) && room);
		push_data = res_s1;
		if (v_s1) begin
			push_data.read_byte = hit_s1 ? name_rdata_q : 8'd0;
		end else begin
			push_data.end_offset  = end_q[dnsdec_pkg::END_W-1:0];
			push_data.name_length = sat_count(cnt_q);
			push_data.read_byte   = 8'd0;
		end
	end

	// memory port control
	always_comb begin
		pkt_we     = accept && (in_req == dnsdec_pkg::REQ_WRITE) &&
		             (AW'(in_pos) < AW'(PKT_DEPTH));
		pkt_re     = 1'b0;
		pkt_raddr  = at_q[PW-1:0];
		name_we    = 1'b0;
		name_waddr = cnt_q;
		name_wdata = dnsdec_pkg::DOT_CHAR;
		name_re    = accept && (in_req == dnsdec_pkg::REQ_READ) && rd_hit;
		unique case (state_q)
			ST_CHECK: begin
				pkt_re = can_step;
			end
			ST_LEN: begin
				pkt_raddr = at_p1[PW-1:0];
				if (!is_zero && is_ptr && !ptr_oob) begin
					pkt_re = 1'b1;
				end else if (!is_zero && !is_ptr && !lab_oob) begin
					pkt_re  = 1'b1;
					name_we = (cnt_q != '0) && name_room;
				end
			end
			ST_COPY: begin
				pkt_raddr  = rd_ptr_q[PW-1:0] + PW'(1);
				pkt_re     = (left_q != 8'd1);
				name_we    = name_room;
				name_wdata = pkt_rdata_q;
			end
			default: begin
			end
		endcase
	end

	// packet memory
	always_ff @(posedge clk) begin
		if (pkt_we) begin
			pkt_mem[in_pos[PW-1:0]] <= in_byte;
		end
		if (pkt_re) begin
			pkt_rdata_q <= pkt_mem[pkt_raddr];
		end
	end

	// name memory
	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[name_waddr] <= name_wdata;
		end
		if (name_re) begin
			name_rdata_q <= name_mem[in_pos[NW-1:0]];
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			if (name_we) begin
				cnt_q <= cnt_q + NW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_req == dnsdec_pkg::REQ_DECODE)) begin
						at_q       <= AW'(in_pos);
						end_q      <= AW'(in_pos);
						bound_q    <= bound_new;
						steps_q    <= '0;
						followed_q <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= can_step ? ST_LEN : ST_DONE;
				end
				ST_LEN: begin
					steps_q <= steps_q + SW'(1);
					if (is_zero) begin
						if (!followed_q) begin
							end_q <= at_p1;
						end
						state_q <= ST_DONE;
					end else if (is_ptr) begin
						if (ptr_oob) begin
							state_q <= ST_DONE;
						end else begin
							if (!followed_q) begin
								end_q <= at_q + AW'(2);
							end
							followed_q <= 1'b1;
							ptr_hi_q   <= len[5:0] & dnsdec_pkg::PTR_LOW[5:0];
							state_q    <= ST_PTR;
						end
					end else if (lab_oob) begin
						state_q <= ST_DONE;
					end else begin
						at_q <= lab_end;
						if (!followed_q) begin
							end_q <= lab_end;
						end
						rd_ptr_q <= at_p1;
						left_q   <= len;
						state_q  <= ST_COPY;
					end
				end
				ST_PTR: begin
					at_q    <= AW'({ptr_hi_q, pkt_rdata_q});
					state_q <= ST_CHECK;
				end
				ST_COPY: begin
					if (left_q == 8'd1) begin
						state_q <= ST_CHECK;
					end else begin
						left_q   <= left_q - 8'd1;
						rd_ptr_q <= rd_ptr_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && (in_req != dnsdec_pkg::REQ_DECODE);
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1             <= (in_req == dnsdec_pkg::REQ_READ) && rd_hit;
			res_s1.end_offset  <= '0;
			res_s1.name_length <= sat_count(cnt_q);
			res_s1.read_byte   <= '0;
		end
	end

	// result buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (!head_v_q) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign m_tvalid = head_v_q;
	assign m_tdata  = {2'b00, head_q};

endmodule

`default_nettype wire

/* design/dnsdec_checker.sv */
`default_nettype none

module dnsdec_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [dnsdec_pkg::S_TUSER_W-1:0] s_tuser,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [dnsdec_pkg::M_TDATA_W-1:0] m_tdata
);

	logic s_beat;

	assign s_beat = s_tvalid && s_tready;

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a result carries either an end offset or a name byte, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] == 14'd0) || (m_tdata[29:22] == 8'd0))
		else $error("result holds both end offset and name byte");

	// a decode blocks the input while it walks
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (s_tuser == dnsdec_pkg::REQ_DECODE) |=> !s_tready)
		else $error("input ready during decode walk");

	// a write, read or idle request shows a result once it passes stage one and the head register
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (s_tuser != dnsdec_pkg::REQ_DECODE) |-> ##2 m_tvalid)
		else $error("no result after write or read request");

endmodule

bind dns_name_decompressor dnsdec_checker u_dnsdec_checker (.*);

`default_nettype wire
